FILE: src/fcsg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared widths, register indexes, sequencer states and helpers for the
// filled circle span generator.
// ----------------------------------------------------------------------------
package fcsg_pkg;

    // fixed field widths
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;
    localparam int RAD_W   = 5;
    localparam int COLOR_W = 32;
    localparam int CFG_IDX_W = 8;

    // parameter defaults
    localparam int DEF_MAX_RADIUS = 31;
    localparam int DEF_IMAGE_DIM  = 4096;
    localparam int DEF_X_W        = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 8'd1;

    // register reset value
    localparam logic [DIM_W-1:0] CFG_DIM_RESET = 13'd4096;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROW,
        ST_SEARCH
    } state_t;

    // decision of the half width step unit
    typedef struct packed {
        logic grow;
        logic shrink;
    } step_ctl_t;

    // zero acts as one, anything above the limit acts as the limit
    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] lim
    );
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > lim)
            res = lim;
        else
            res = v;
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: src/filled_circle_span_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Turns one circle command into one clipped horizontal span per image row.
// ----------------------------------------------------------------------------
// One circle is handled at a time; in_stall stays high from the accepted item
// until its last span has been placed in the output register. Each row first
// sets up its remainder, then searches the half width, then places its span in
// a final search step, which waits while the sink stalls the output register.
// A single add/compare step unit moves the half width by one per cycle. A span
// waits in the output register while the next row is searched. A circle that
// lies wholly below the image gives no span and goes from its setup state
// straight back to idle, which frees the input.
// Radii above MAX_RADIUS saturate; image sizes of zero act as one and sizes
// above IMAGE_DIM act as IMAGE_DIM.
// ----------------------------------------------------------------------------
module filled_circle_span_generator #(
    parameter int MAX_RADIUS = fcsg_pkg::DEF_MAX_RADIUS,
    parameter int IMAGE_DIM  = fcsg_pkg::DEF_IMAGE_DIM
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // circle command channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [fcsg_pkg::COORD_W-1:0]      center_x,
    input  wire logic [fcsg_pkg::COORD_W-1:0]      center_y,
    input  wire logic [fcsg_pkg::RAD_W-1:0]        circle_radius,
    input  wire logic [fcsg_pkg::COLOR_W-1:0]      circle_color,
    // span channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [fcsg_pkg::COORD_W-1:0]      row_index,
    output logic      [fcsg_pkg::COORD_W-1:0]      span_left,
    output logic      [fcsg_pkg::COORD_W-1:0]      span_right,
    output logic                                   span_empty,
    output logic      [fcsg_pkg::COLOR_W-1:0]      fill_color,
    output logic                                   last_span,
    // register write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [fcsg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fcsg_pkg::DIM_W-1:0]        cfg_data
);

    localparam int XW   = $clog2(MAX_RADIUS + 1);
    localparam int SQW  = 2 * XW;
    localparam int CW   = fcsg_pkg::COORD_W;
    localparam int DW   = fcsg_pkg::DIM_W;
    localparam logic [DW-1:0] DIM_LIM = DW'(IMAGE_DIM);
    localparam logic [fcsg_pkg::RAD_W-1:0] RAD_LIM = fcsg_pkg::RAD_W'(MAX_RADIUS);

    fcsg_pkg::state_t state_reg, state_next;

    logic [DW-1:0]                  width_reg, height_reg;
    logic [CW-1:0]                  cx_reg, cy_reg;
    logic [XW-1:0]                  r_reg;
    logic [fcsg_pkg::COLOR_W-1:0]   color_reg;
    logic [CW-1:0]                  y_reg, y_next;
    logic [CW-1:0]                  ybot_reg, ybot_next;
    logic [SQW-1:0]                 rr_reg, rr_next;
    logic [SQW-1:0]                 rem_reg, rem_next;
    logic [XW-1:0]                  x_reg;
    logic [SQW-1:0]                 sq_reg;

    logic                           out_valid_reg, out_valid_next;
    logic [CW-1:0]                  row_reg, left_reg, right_reg;
    logic                           empty_reg, last_reg;
    logic [fcsg_pkg::COLOR_W-1:0]   fcolor_reg;

    // control from the sequencer
    logic take_in, do_setup, do_row, do_step, load_out, slot_free, rows_none;

    // step unit
    fcsg_pkg::step_ctl_t step_ctl;
    logic [XW-1:0]       step_x;
    logic [SQW-1:0]      step_sq;
    logic                step_done;

    fcsg_step_unit #(
        .XW (XW)
    ) u_step (
        .x       (x_reg),
        .sq      (sq_reg),
        .rem     (rem_reg),
        .ctl     (step_ctl),
        .x_next  (step_x),
        .sq_next (step_sq)
    );

    assign step_done = !step_ctl.grow && !step_ctl.shrink;

    // saturated radius of the incoming item
    logic [fcsg_pkg::RAD_W-1:0] r_sat;
    assign r_sat = (circle_radius > RAD_LIM) ? RAD_LIM : circle_radius;

    // row range of the circle, clipped to the image height
    logic [CW-1:0] ytop;
    logic [DW-1:0] ybot_full, h_last, ybot_clip;
    always_comb
    begin
        ytop      = (cy_reg >= CW'(r_reg)) ? (cy_reg - CW'(r_reg)) : '0;
        ybot_full = {1'b0, cy_reg} + DW'(r_reg);
        h_last    = fcsg_pkg::clamp_dim(height_reg, DIM_LIM) - DW'(1);
        ybot_clip = (ybot_full > h_last) ? h_last : ybot_full;
        ybot_next = ybot_clip[CW-1:0];
        rows_none = ({1'b0, ytop} > ybot_clip);
        rr_next   = SQW'(r_reg) * SQW'(r_reg);
    end

    // remainder r*r - dy*dy for the current row
    logic [CW-1:0] dy_full;
    logic [XW-1:0] dy;
    always_comb
    begin
        dy_full  = (y_reg > cy_reg) ? (y_reg - cy_reg) : (cy_reg - y_reg);
        dy       = dy_full[XW-1:0];
        rem_next = rr_reg - SQW'(dy) * SQW'(dy);
    end

    // span ends clipped to the image width
    logic [DW-1:0] w_last, right_full, right_clip;
    logic [CW-1:0] left_clip;
    logic          empty_now;
    always_comb
    begin
        w_last     = fcsg_pkg::clamp_dim(width_reg, DIM_LIM) - DW'(1);
        left_clip  = (cx_reg >= CW'(x_reg)) ? (cx_reg - CW'(x_reg)) : '0;
        right_full = {1'b0, cx_reg} + DW'(x_reg);
        right_clip = (right_full > w_last) ? w_last : right_full;
        empty_now  = ({1'b0, left_clip} > right_clip);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcsg_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = fcsg_pkg::ST_SETUP;
            end
            fcsg_pkg::ST_SETUP:
            begin
                state_next = rows_none ? fcsg_pkg::ST_IDLE : fcsg_pkg::ST_ROW;
            end
            fcsg_pkg::ST_ROW:
            begin
                state_next = fcsg_pkg::ST_SEARCH;
            end
            fcsg_pkg::ST_SEARCH:
            begin
                if (step_done && slot_free)
                    state_next = (y_reg == ybot_reg) ? fcsg_pkg::ST_IDLE
                                                     : fcsg_pkg::ST_ROW;
            end
            default:
            begin
                state_next = fcsg_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        take_in   = 1'b0;
        do_setup  = 1'b0;
        do_row    = 1'b0;
        do_step   = 1'b0;
        load_out  = 1'b0;
        slot_free = !out_valid_reg || !out_stall;
        unique case (state_reg)
            fcsg_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                take_in  = in_valid;
            end
            fcsg_pkg::ST_SETUP:
            begin
                do_setup = 1'b1;
            end
            fcsg_pkg::ST_ROW:
            begin
                do_row = 1'b1;
            end
            fcsg_pkg::ST_SEARCH:
            begin
                do_step  = !step_done;
                load_out = step_done && slot_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign y_next         = y_reg + CW'(1);
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcsg_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            width_reg     <= fcsg_pkg::CFG_DIM_RESET;
            height_reg    <= fcsg_pkg::CFG_DIM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == fcsg_pkg::CFG_IMAGE_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_index == fcsg_pkg::CFG_IMAGE_HEIGHT)
                    height_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            cx_reg    <= center_x;
            cy_reg    <= center_y;
            r_reg     <= r_sat[XW-1:0];
            color_reg <= circle_color;
        end
        if (do_setup)
        begin
            y_reg    <= ytop;
            ybot_reg <= ybot_next;
            rr_reg   <= rr_next;
            x_reg    <= '0;
            sq_reg   <= '0;
        end
        if (do_row)
            rem_reg <= rem_next;
        if (do_step)
        begin
            x_reg  <= step_x;
            sq_reg <= step_sq;
        end
        if (load_out)
        begin
            row_reg    <= y_reg;
            left_reg   <= empty_now ? '0 : left_clip;
            right_reg  <= empty_now ? '0 : right_clip[CW-1:0];
            empty_reg  <= empty_now;
            fcolor_reg <= color_reg;
            last_reg   <= (y_reg == ybot_reg);
            y_reg      <= y_next;
        end
    end

    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign row_index  = row_reg;
    assign span_left  = left_reg;
    assign span_right = right_reg;
    assign span_empty = empty_reg;
    assign fill_color = fcolor_reg;
    assign last_span  = last_reg;

endmodule
`default_nettype wire

FILE: src/fcsg_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_step_unit
// One step of the half width search: moves x by one toward the largest
// value whose square does not exceed the remainder, tracking x*x by adds and subtracts.
// ----------------------------------------------------------------------------
module fcsg_step_unit #(
    parameter int XW = fcsg_pkg::DEF_X_W
) (
    input  wire logic [XW-1:0]     x,
    input  wire logic [2*XW-1:0]   sq,
    input  wire logic [2*XW-1:0]   rem,
    output fcsg_pkg::step_ctl_t    ctl,
    output logic      [XW-1:0]     x_next,
    output logic      [2*XW-1:0]   sq_next
);

    localparam int SQW = 2 * XW;

    logic [SQW:0] twice_x;
    logic [SQW:0] up_sq;
    logic [SQW:0] down_sq;

    // (x+1)^2 = x^2 + 2x + 1, (x-1)^2 = x^2 - 2x + 1
    assign twice_x = {{(SQW - XW){1'b0}}, x, 1'b0};
    assign up_sq   = {1'b0, sq} + twice_x + (SQW + 1)'(1);
    assign down_sq = {1'b0, sq} - twice_x + (SQW + 1)'(1);

    // grow while the next square fits, shrink while the current one does not
    assign ctl.grow   = (up_sq <= {1'b0, rem});
    assign ctl.shrink = !ctl.grow && (sq > rem);

    always_comb
    begin
        priority if (ctl.grow)
        begin
            x_next  = x + XW'(1);
            sq_next = up_sq[SQW-1:0];
        end
        else if (ctl.shrink)
        begin
            x_next  = x - XW'(1);
            sq_next = down_sq[SQW-1:0];
        end
        else
        begin
            x_next  = x;
            sq_next = sq;
        end
    end

endmodule
`default_nettype wire

FILE: src/fcsg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fcsg_checker
// Port level checks of the filled circle span generator, bound to the top.
// ----------------------------------------------------------------------------
module fcsg_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic [fcsg_pkg::COORD_W-1:0]      row_index,
    input wire logic [fcsg_pkg::COORD_W-1:0]      span_left,
    input wire logic [fcsg_pkg::COORD_W-1:0]      span_right,
    input wire logic                              span_empty,
    input wire logic [fcsg_pkg::COLOR_W-1:0]      fill_color,
    input wire logic                              last_span
);

    // a stalled span holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_index)
            && $stable(span_left) && $stable(span_right) && $stable(last_span)
            && $stable(span_empty) && $stable(fill_color))
        else $error("stalled span changed");

    // an empty span reports zero ends
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && span_empty |-> span_left == '0 && span_right == '0)
        else $error("empty span with nonzero ends");

    // a filled span is ordered
    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !span_empty |-> span_left <= span_right)
        else $error("span left end past right end");

    // the block is busy right after taking a circle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a circle is in work");

    // rows of one circle advance by one
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_span ##1 out_valid
            |-> row_index == $past(row_index) + fcsg_pkg::COORD_W'(1))
        else $error("span rows out of order");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the filled circle span generator. A table of
// directed circles runs first, across several image sizes. Random circles
// follow, placed around the configured image so that clipping is hit often.
// Most accepted circles are turned into their expected row spans by a local
// span planner; some directed ones carry one typed span or expect none. Each
// span that leaves the block is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int COORD_W   = fcsg_pkg::COORD_W;
    localparam int DIM_W     = fcsg_pkg::DIM_W;
    localparam int RAD_W     = fcsg_pkg::RAD_W;
    localparam int COLOR_W   = fcsg_pkg::COLOR_W;
    localparam int CFG_IDX_W = fcsg_pkg::CFG_IDX_W;
    localparam logic [DIM_W-1:0]     CFG_DIM_RESET    = fcsg_pkg::CFG_DIM_RESET;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = fcsg_pkg::CFG_IMAGE_WIDTH;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = fcsg_pkg::CFG_IMAGE_HEIGHT;

    localparam int CLK_HIGH        = 6;
    localparam int CLK_LOW         = 6;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 256;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 57;
    localparam int RADIUS_LIMIT    = fcsg_pkg::DEF_MAX_RADIUS;
    localparam int DIM_LIMIT       = fcsg_pkg::DEF_IMAGE_DIM;
    localparam int COORD_MAX       = (1 << COORD_W) - 1;
    // index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'd2;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic               empty;
        logic [COLOR_W-1:0] color;
        logic               last;
    } span_t;

    // how the spans of a directed circle are checked
    typedef enum logic [1:0] {
        CHECK_PLANNED,
        CHECK_ONE_SPAN,
        CHECK_NO_SPAN
    } check_kind_t;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [RAD_W-1:0]   radius;
        logic [COLOR_W-1:0] color;
        check_kind_t        kind;
        span_t              span;
    } directed_circle_t;

    // receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_LIGHT,
        RX_PERIODIC,
        RX_HEAVY
    } stall_mode_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [COORD_W-1:0]   center_x = '0;
    logic [COORD_W-1:0]   center_y = '0;
    logic [RAD_W-1:0]     circle_radius = '0;
    logic [COLOR_W-1:0]   circle_color = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [COORD_W-1:0]   row_index;
    logic [COORD_W-1:0]   span_left;
    logic [COORD_W-1:0]   span_right;
    logic                 span_empty;
    logic [COLOR_W-1:0]   fill_color;
    logic                 last_span;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    // local copy of the image size registers
    logic [DIM_W-1:0]     width_reg = CFG_DIM_RESET;
    logic [DIM_W-1:0]     height_reg = CFG_DIM_RESET;

    span_t                pending_spans[$];
    directed_circle_t     directed_circles[$];
    int                   mismatch_count = 0;
    int                   cycle_count = 0;
    int                   burst_left = 1;
    stall_mode_t          stall_mode = RX_OPEN;
    int                   stall_mode_left = 0;
    span_t                want_span;

    filled_circle_span_generator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .center_x      (center_x),
        .center_y      (center_y),
        .circle_radius (circle_radius),
        .circle_color  (circle_color),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .row_index     (row_index),
        .span_left     (span_left),
        .span_right    (span_right),
        .span_empty    (span_empty),
        .fill_color    (fill_color),
        .last_span     (last_span),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d spans outstanding",
                     cycle_count, pending_spans.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // append one expected span at the tail of the queue
    function automatic void enqueue_span(input span_t s);
        pending_spans.insert(pending_spans.size(), s);
    endfunction

    // append one row of the directed table
    function automatic void add_directed(input directed_circle_t d);
        directed_circles.insert(directed_circles.size(), d);
    endfunction

    // image size as the block sees it: zero acts as one, large values saturate
    function automatic int usable_dim(input logic [DIM_W-1:0] v);
        int d;
        d = v;
        if (d == 0)
            d = 1;
        else if (d > DIM_LIMIT)
            d = DIM_LIMIT;
        return d;
    endfunction

    // expected row spans of one circle under the current image size
    function automatic void plan_circle_spans(
        input logic [COORD_W-1:0] cx_in,
        input logic [COORD_W-1:0] cy_in,
        input logic [RAD_W-1:0]   rad_in,
        input logic [COLOR_W-1:0] color
    );
        int    w, h, cx, cy, r, ytop, ybot, y, dy, rem, x, left, right;
        span_t s;
        w  = usable_dim(width_reg);
        h  = usable_dim(height_reg);
        cx = cx_in;
        cy = cy_in;
        r  = rad_in;
        if (r > RADIUS_LIMIT)
            r = RADIUS_LIMIT;
        ytop = (cy >= r) ? cy - r : 0;
        ybot = cy + r;
        if (ybot > h - 1)
            ybot = h - 1;
        for (y = ytop; y <= ybot; y++)
        begin
            dy  = (y > cy) ? y - cy : cy - y;
            rem = r * r - dy * dy;
            x   = 0;
            while ((x + 1) * (x + 1) <= rem)
                x++;
            left  = cx - x;
            right = cx + x;
            if (left < 0)
                left = 0;
            if (right > w - 1)
                right = w - 1;
            s.row   = COORD_W'(y);
            s.empty = (left > right);
            s.left  = s.empty ? '0 : COORD_W'(left);
            s.right = s.empty ? '0 : COORD_W'(right);
            s.color = color;
            s.last  = (y == ybot);
            enqueue_span(s);
        end
    endfunction

    function automatic directed_circle_t directed_circle(
        input int unsigned        w,
        input int unsigned        h,
        input int unsigned        cx,
        input int unsigned        cy,
        input int unsigned        r,
        input logic [COLOR_W-1:0] color,
        input check_kind_t        kind,
        input int unsigned        row,
        input int unsigned        left,
        input int unsigned        right,
        input logic               empty
    );
        directed_circle_t d;
        d.width      = DIM_W'(w);
        d.height     = DIM_W'(h);
        d.cx         = COORD_W'(cx);
        d.cy         = COORD_W'(cy);
        d.radius     = RAD_W'(r);
        d.color      = color;
        d.kind       = kind;
        d.span.row   = COORD_W'(row);
        d.span.left  = COORD_W'(left);
        d.span.right = COORD_W'(right);
        d.span.empty = empty;
        d.span.color = color;
        d.span.last  = 1'b1;
        return d;
    endfunction

    // coordinate near the start or the far edge of an image dimension
    function automatic int near_edge(input int dim);
        int v;
        if ($urandom_range(0, 1) == 0)
            v = $urandom_range(0, 8);
        else
            v = dim - 9 + $urandom_range(0, 48);
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] span mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_IMAGE_WIDTH)
            width_reg = value;
        else if (idx == CFG_IMAGE_HEIGHT)
            height_reg = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // drop valid, let every planned span arrive, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_spans.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic set_image_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        wait_idle();
        write_register(CFG_IMAGE_WIDTH, w);
        write_register(CFG_IMAGE_HEIGHT, h);
    endtask

    // present one circle and hold it until the block takes it
    task automatic send_circle(
        input logic [COORD_W-1:0] cx,
        input logic [COORD_W-1:0] cy,
        input logic [RAD_W-1:0]   r,
        input logic [COLOR_W-1:0] color,
        input check_kind_t        kind,
        input span_t              typed_span
    );
        @(negedge clk);
        in_valid      = 1'b1;
        center_x      = cx;
        center_y      = cy;
        circle_radius = r;
        circle_color  = color;
        do
            @(posedge clk);
        while (in_stall);
        case (kind)
            CHECK_ONE_SPAN: enqueue_span(typed_span);
            CHECK_NO_SPAN:  ;
            default:        plan_circle_spans(cx, cy, r, color);
        endcase
    endtask

    // sender bursts: valid stays up inside a burst, random gap after it
    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid      = 1'b0;
            center_x      = COORD_W'($urandom);
            center_y      = COORD_W'($urandom);
            circle_radius = RAD_W'($urandom);
            circle_color  = $urandom;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(0, 40)) @(negedge clk);
            else
                repeat ($urandom_range(0, 4)) @(negedge clk);
            burst_left = $urandom_range(1, 8);
        end
    endtask

    // receiver stall pattern, switched at random
    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = stall_mode_t'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(8, 80);
        end
        else
        begin
            stall_mode_left--;
        end
        case (stall_mode)
            RX_OPEN:     out_stall = 1'b0;
            RX_LIGHT:    out_stall = ($urandom_range(0, 3) == 0);
            RX_PERIODIC: out_stall = (cycle_count % 3 == 0);
            default:     out_stall = ($urandom_range(0, 2) != 0);
        endcase
    end

    // span checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_spans.size() == 0)
            begin
                report_mismatch("row_index (no span pending)", row_index, 0);
            end
            else
            begin
                want_span = pending_spans.pop_front();
                if (row_index !== want_span.row)
                    report_mismatch("row_index", row_index, want_span.row);
                if (span_left !== want_span.left)
                    report_mismatch("span_left", span_left, want_span.left);
                if (span_right !== want_span.right)
                    report_mismatch("span_right", span_right, want_span.right);
                if (span_empty !== want_span.empty)
                    report_mismatch("span_empty", span_empty, want_span.empty);
                if (fill_color !== want_span.color)
                    report_mismatch("fill_color", fill_color, want_span.color);
                if (last_span !== want_span.last)
                    report_mismatch("last_span", last_span, want_span.last);
            end
        end
    end

    // stimulus
    initial
    begin
        directed_circle_t dc;
        int               w_eff, h_eff, sel, cx, cy, lim;
        logic [DIM_W-1:0] w_set, h_set;

        // reset size: single pixels at both corners, full and clipped circles
        add_directed(directed_circle(4096, 4096, 0, 0, 0, 32'h0000_0000,
                                     CHECK_ONE_SPAN, 0, 0, 0, 1'b0));
        add_directed(directed_circle(4096, 4096, 4095, 4095, 0, 32'hFFFF_FFFF,
                                     CHECK_ONE_SPAN, 4095, 4095, 4095, 1'b0));
        add_directed(directed_circle(4096, 4096, 2048, 2048, 31, 32'hA5A5_A5A5,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(4096, 4096, 0, 0, 31, 32'h5A5A_5A5A,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(4096, 4096, 4095, 4095, 31, 32'h8000_0001,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(4096, 4096, 100, 50, 1, 32'h0123_4567,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(4096, 4096, 4095, 10, 5, 32'h89AB_CDEF,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        // tiny image: empty rows, circle below the image, both-side clipping
        add_directed(directed_circle(16, 16, 20, 5, 3, 32'h7FFF_FFFF,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(16, 16, 8, 100, 10, 32'h1111_2222,
                                     CHECK_NO_SPAN, 0, 0, 0, 1'b0));
        add_directed(directed_circle(16, 16, 8, 8, 31, 32'h3333_4444,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(16, 16, 15, 15, 0, 32'h5555_6666,
                                     CHECK_ONE_SPAN, 15, 15, 15, 1'b0));
        add_directed(directed_circle(16, 16, 16, 0, 0, 32'h7777_8888,
                                     CHECK_ONE_SPAN, 0, 0, 0, 1'b1));
        // zero size acts as a single pixel
        add_directed(directed_circle(0, 0, 0, 0, 0, 32'h9999_AAAA,
                                     CHECK_ONE_SPAN, 0, 0, 0, 1'b0));
        add_directed(directed_circle(0, 0, 0, 0, 31, 32'hBBBB_CCCC,
                                     CHECK_ONE_SPAN, 0, 0, 0, 1'b0));
        add_directed(directed_circle(0, 0, 0, 1, 0, 32'hDDDD_EEEE,
                                     CHECK_NO_SPAN, 0, 0, 0, 1'b0));
        add_directed(directed_circle(0, 0, 5, 0, 3, 32'hF0F0_0F0F,
                                     CHECK_ONE_SPAN, 0, 0, 0, 1'b1));
        // oversized registers saturate to the full image
        add_directed(directed_circle(8191, 5000, 4095, 4095, 31, 32'hCAFE_F00D,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(8191, 5000, 4095, 4095, 0, 32'h0F0F_F0F0,
                                     CHECK_ONE_SPAN, 4095, 4095, 4095, 1'b0));
        add_directed(directed_circle(8191, 5000, 0, 0, 1, 32'h0000_FFFF,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        // one row high
        add_directed(directed_circle(4097, 1, 3000, 0, 2, 32'hFFFF_0000,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(4097, 1, 0, 4095, 31, 32'h1234_5678,
                                     CHECK_NO_SPAN, 0, 0, 0, 1'b0));
        add_directed(directed_circle(4097, 1, 4095, 0, 31, 32'h8765_4321,
                                     CHECK_ONE_SPAN, 0, 4064, 4095, 1'b0));
        // one column wide
        add_directed(directed_circle(1, 4096, 0, 2000, 4, 32'hDEAD_BEEF,
                                     CHECK_PLANNED, 0, 0, 0, 1'b0));
        add_directed(directed_circle(1, 4096, 1, 10, 0, 32'hBEEF_DEAD,
                                     CHECK_ONE_SPAN, 10, 0, 0, 1'b1));

        // reset
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed circles
        burst_left = $urandom_range(1, 8);
        foreach (directed_circles[i])
        begin
            dc = directed_circles[i];
            if (dc.width != width_reg || dc.height != height_reg)
                set_image_size(dc.width, dc.height);
            send_circle(dc.cx, dc.cy, dc.radius, dc.color, dc.kind, dc.span);
            pace_sender();
        end

        // random circles, one image size per phase
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:
                begin
                    w_set = 13'd4096;
                    h_set = 13'd4096;
                end
                1:
                begin
                    w_set = 13'd640;
                    h_set = 13'd480;
                end
                2:
                begin
                    w_set = 13'd16;
                    h_set = 13'd24;
                end
                3:
                begin
                    w_set = 13'd200;
                    h_set = 13'd4096;
                end
                default:
                begin
                    w_set = DIM_W'($urandom_range(0, 8191));
                    h_set = DIM_W'($urandom_range(0, 8191));
                end
            endcase
            set_image_size(w_set, h_set);
            if (phase == 0)
                write_register(CFG_UNMAPPED, DIM_W'($urandom));
            w_eff = usable_dim(width_reg);
            h_eff = usable_dim(height_reg);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                begin
                    lim = (w_eff + 40 > COORD_MAX) ? COORD_MAX : w_eff + 40;
                    cx  = $urandom_range(0, lim);
                    lim = (h_eff + 40 > COORD_MAX) ? COORD_MAX : h_eff + 40;
                    cy  = $urandom_range(0, lim);
                end
                else if (sel < 8)
                begin
                    cx = near_edge(w_eff);
                    cy = near_edge(h_eff);
                end
                else
                begin
                    cx = $urandom_range(0, COORD_MAX);
                    cy = $urandom_range(0, COORD_MAX);
                end
                send_circle(COORD_W'(cx), COORD_W'(cy), RAD_W'($urandom_range(0, 31)),
                            $urandom, CHECK_PLANNED, '0);
                pace_sender();
            end
        end

        // drain and finish
        wait_idle();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
